// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the timer table RTL.
// Depends on nothing; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked at the next clock edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/ospt_pkg.sv -----
// Package for the one-shot and periodic timer table.
// Holds item structs and operation and result codes; no dependencies.
package ospt_pkg;
	localparam int TS_W = 48;
	localparam int CNT_W = 32;
	localparam int ID_W = 16;
	localparam logic [TS_W-1:0] TS_MAX = {TS_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam int RESULT_LIMIT = 16;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_ARM_ONCE = 2'd1;
	localparam logic [1:0] OP_ARM_PERIODIC = 2'd2;
	localparam logic [1:0] OP_CANCEL = 2'd3;

	localparam logic [1:0] KIND_ARMED = 2'd0;
	localparam logic [1:0] KIND_EXPIRED = 2'd1;
	localparam logic [1:0] KIND_FULL = 2'd2;
	localparam logic [1:0] KIND_ZERO_PERIOD = 2'd3;

	typedef struct packed {
		logic [1:0] operation;
		logic [TS_W-1:0] now;
		logic [ID_W-1:0] target_id;
		logic [CNT_W-1:0] delay;
		logic [ID_W-1:0] cancel_id;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [ID_W-1:0] timer_id;
		logic [ID_W-1:0] target;
		logic [CNT_W-1:0] timeouts;
		logic last;
	} out_item_t;
endpackage

// ----- rtl/core/one_shot_and_periodic_timer_table.sv -----
// Top level of the one-shot and periodic timer table.
// Depends on ospt_pkg and assert_macros.svh.
//
// Usage: items enter on in_valid/in_item (in_stall low accepts them) and
// results leave on out_valid/out_item (out_stall from the receiver).
// Arm items (one-shot or periodic) give one result: the new id, table full
// or zero period. Cancel gives no result. A tick reports every due timer,
// earliest deadline first, ties to the lower id, at most 16 per tick, with
// last set on the final one; a tick with nothing due gives no result.
// One item is worked on at a time; in_stall is high until it is done.
// Steps: an arm or a cancel keeps the block for one slot scan plus a
// closing step, in which the arm result is loaded into the output
// register. A tick runs an earliest-deadline scan for each report; a
// periodic report adds a bit-serial divider that counts missed periods
// and a shift-add multiply that advances its deadline. One final scan
// that finds nothing ends the tick.
// Reset clears every valid bit and the id counter at once; no clearing pass.
// When out_stall is high the held result waits in the output register and
// the sequencer waits with it once it has a new result to load.
module one_shot_and_periodic_timer_table #(
	parameter int TIMER_SLOTS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input ospt_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output ospt_pkg::out_item_t out_item
);
	import ospt_pkg::*;
	`include "assert_macros.svh"

	localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CW = $clog2(TIMER_SLOTS + 1);
	localparam int RW = $clog2(RESULT_LIMIT + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_ARM_SCAN, ST_CANCEL, ST_SCAN, ST_DIV, ST_MUL, ST_EMIT, ST_OUT
	} state_t;

	state_t state_q;
	in_item_t item_q;

	logic [TIMER_SLOTS-1:0] valid_q;
	logic [TIMER_SLOTS-1:0] done_q;
	logic [ID_W-1:0] slot_id_q [TIMER_SLOTS];
	logic [ID_W-1:0] slot_target_q [TIMER_SLOTS];
	logic [TS_W-1:0] slot_deadline_q [TIMER_SLOTS];
	logic slot_periodic_q [TIMER_SLOTS];
	logic [CNT_W-1:0] slot_period_q [TIMER_SLOTS];
	logic [ID_W-1:0] next_id_q;

	logic [CW-1:0] idx_q;
	logic found_q;
	logic [SW-1:0] best_q;
	logic [TS_W-1:0] best_dl_q;
	logic [ID_W-1:0] best_id_q;
	logic [RW-1:0] nrep_q;
	logic pend_q;
	out_item_t pend_item_q;

	// Divider and multiplier registers; step_q is shared by both.
	logic [TS_W-1:0] quo_q;
	logic [CNT_W:0] rem_q;
	logic [5:0] step_q;
	logic [CNT_W-1:0] cnt_q;
	logic [TS_W+CNT_W-1:0] acc_q;

	logic out_valid_q;
	out_item_t out_item_q;

	logic [SW-1:0] idx_s;
	logic [SW-1:0] free_s;
	logic [TS_W:0] arm_sum;
	logic [TS_W-1:0] arm_dl;
	logic [CNT_W:0] rem_shift;
	logic [TS_W+CNT_W:0] adv_sum;
	logic out_free;
	logic out_load;
	logic better;
	logic arm_zero;
	out_item_t arm_res;
	out_item_t pend_last;

	assign idx_s = idx_q[SW-1:0];
	assign free_s = idx_s;
	assign arm_sum = {1'b0, item_q.now} + {{(TS_W-CNT_W+1){1'b0}}, item_q.delay};
	assign arm_dl = arm_sum[TS_W] ? TS_MAX : arm_sum[TS_W-1:0];
	assign rem_shift = {rem_q[CNT_W-1:0], quo_q[TS_W-1]};
	assign adv_sum = {1'b0, acc_q} + {{(CNT_W+1){1'b0}}, slot_deadline_q[best_q]};
	assign out_free = !out_valid_q || !out_stall;
	assign better = !found_q || slot_deadline_q[idx_s] < best_dl_q
		|| (slot_deadline_q[idx_s] == best_dl_q && slot_id_q[idx_s] < best_id_q);
	assign arm_zero = (item_q.operation == OP_ARM_PERIODIC) && (item_q.delay == '0);

	// A new result goes into the output register in these cycles only.
	assign out_load = out_free && (
		(state_q == ST_ARM_SCAN && idx_q == CW'(TIMER_SLOTS))
		|| (state_q == ST_SCAN && idx_q == CW'(TIMER_SLOTS) && !found_q && pend_q)
		|| (state_q == ST_EMIT && pend_q)
		|| (state_q == ST_OUT));

	always_comb begin
		arm_res = '0;
		arm_res.last = 1'b1;
		if (arm_zero) begin
			arm_res.kind = KIND_ZERO_PERIOD;
		end else if (!found_q) begin
			arm_res.kind = KIND_FULL;
		end else begin
			arm_res.kind = KIND_ARMED;
			arm_res.timer_id = next_id_q;
		end
	end

	always_comb begin
		pend_last = pend_item_q;
		pend_last.last = 1'b1;
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_ARM_SCAN && idx_q == CW'(TIMER_SLOTS) && found_q && out_free) begin
			slot_id_q[best_q] <= next_id_q;
			slot_target_q[best_q] <= item_q.target_id;
			slot_deadline_q[best_q] <= arm_dl;
			slot_periodic_q[best_q] <= (item_q.operation == OP_ARM_PERIODIC);
			slot_period_q[best_q] <= item_q.delay;
		end
		if (state_q == ST_MUL && step_q == 6'd0) begin
			if (adv_sum[TS_W+CNT_W:TS_W] != '0)
				slot_deadline_q[best_q] <= TS_MAX;
			else
				slot_deadline_q[best_q] <= adv_sum[TS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			done_q <= '0;
			next_id_q <= '0;
			idx_q <= '0;
			found_q <= 1'b0;
			nrep_q <= '0;
			pend_q <= 1'b0;
			out_valid_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						item_q <= in_item;
						idx_q <= '0;
						found_q <= 1'b0;
						done_q <= '0;
						nrep_q <= '0;
						pend_q <= 1'b0;
						case (in_item.operation)
							OP_TICK: state_q <= ST_SCAN;
							OP_CANCEL: state_q <= ST_CANCEL;
							default: state_q <= ST_ARM_SCAN;
						endcase
					end
				end
				ST_ARM_SCAN: begin
					if (idx_q != CW'(TIMER_SLOTS)) begin
						if (!found_q && !valid_q[idx_s]) begin
							found_q <= 1'b1;
							best_q <= free_s;
						end
						idx_q <= idx_q + 1'b1;
					end else if (out_free) begin
						out_item_q <= arm_res;
						if (!arm_zero && found_q) begin
							valid_q[best_q] <= 1'b1;
							next_id_q <= next_id_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_CANCEL: begin
					if (idx_q != CW'(TIMER_SLOTS)) begin
						if (valid_q[idx_s] && slot_id_q[idx_s] == item_q.cancel_id)
							valid_q[idx_s] <= 1'b0;
						idx_q <= idx_q + 1'b1;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (idx_q != CW'(TIMER_SLOTS)) begin
						if (valid_q[idx_s] && !done_q[idx_s]
								&& slot_deadline_q[idx_s] <= item_q.now && better) begin
							found_q <= 1'b1;
							best_q <= idx_s;
							best_dl_q <= slot_deadline_q[idx_s];
							best_id_q <= slot_id_q[idx_s];
						end
						idx_q <= idx_q + 1'b1;
					end else if (!found_q) begin
						// Nothing more due: flush the held report as the last one.
						if (!pend_q) begin
							state_q <= ST_IDLE;
						end else if (out_free) begin
							out_item_q <= pend_last;
							pend_q <= 1'b0;
							state_q <= ST_IDLE;
						end
					end else begin
						done_q[best_q] <= 1'b1;
						quo_q <= item_q.now - best_dl_q;
						rem_q <= '0;
						step_q <= 6'(TS_W);
						state_q <= (slot_periodic_q[best_q]) ? ST_DIV : ST_EMIT;
						cnt_q <= CNT_W'(1);
					end
				end
				ST_DIV: begin
					// Restoring division, one quotient bit per cycle.
					if (step_q != 6'd0) begin
						if (rem_shift >= {1'b0, slot_period_q[best_q]}) begin
							rem_q <= rem_shift - {1'b0, slot_period_q[best_q]};
							quo_q <= {quo_q[TS_W-2:0], 1'b1};
						end else begin
							rem_q <= rem_shift;
							quo_q <= {quo_q[TS_W-2:0], 1'b0};
						end
						step_q <= step_q - 1'b1;
					end else begin
						if (quo_q >= {{(TS_W-CNT_W){1'b0}}, CNT_MAX})
							cnt_q <= CNT_MAX;
						else
							cnt_q <= quo_q[CNT_W-1:0] + 1'b1;
						acc_q <= '0;
						step_q <= 6'(CNT_W);
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					// Shift-add multiply period by count, msb of count first.
					if (step_q != 6'd0) begin
						acc_q <= (acc_q << 1) + ((cnt_q[5'(step_q - 6'd1)] == 1'b1)
							? {{TS_W{1'b0}}, slot_period_q[best_q]} : '0);
						step_q <= step_q - 1'b1;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!pend_q || out_free) begin
						if (pend_q)
							out_item_q <= pend_item_q;
						pend_q <= 1'b1;
						pend_item_q.kind <= KIND_EXPIRED;
						pend_item_q.timer_id <= slot_id_q[best_q];
						pend_item_q.target <= slot_target_q[best_q];
						pend_item_q.timeouts <= cnt_q;
						pend_item_q.last <= 1'b0;
						if (!slot_periodic_q[best_q])
							valid_q[best_q] <= 1'b0;
						nrep_q <= nrep_q + 1'b1;
						idx_q <= '0;
						found_q <= 1'b0;
						state_q <= (nrep_q == RW'(RESULT_LIMIT - 1)) ? ST_OUT : ST_SCAN;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_item_q <= pend_last;
						pend_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_ALWAYS(a_busy_stall, clk, arst_n, (state_q == ST_IDLE) || in_stall, "busy")
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid_q && out_stall, out_valid_q && $stable(out_item_q), "held result changed")
	`ASSERT_ALWAYS(a_rep_limit, clk, arst_n, nrep_q <= RW'(RESULT_LIMIT), "too many reports")
	`ASSERT_NEXT(a_id_step, clk, arst_n, state_q == ST_IDLE, next_id_q == $past(next_id_q), "id moved")
endmodule
